/* hw/rtl/lrf_pkg.sv */
// Shared types, constants and helper functions of the LED rainbow flash frame engine.
`default_nettype none

package lrf_pkg;

   // Geometry defaults.
   localparam int PIXEL_COUNT_DEFAULT = 64;
   localparam int ROW_LENGTH_DEFAULT  = 8;

   // Field widths.
   localparam int INDEX_W     = 6;
   localparam int LEVEL_W     = 8;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int RAND_W      = 16;

   // Register reset values.
   localparam logic [INDEX_W-1:0] ROTATE_RESET    = 6'd6;
   localparam logic [LEVEL_W-1:0] DECAY_RESET     = 8'd0;
   localparam logic [LEVEL_W-1:0] PEAK_RESET      = 8'd255;
   localparam logic [LEVEL_W-1:0] FLOOR_RESET     = 8'd0;
   localparam logic [RAND_W-1:0]  THRESHOLD_RESET = 16'd66;
   localparam logic [RAND_W-1:0]  SEED_RESET      = 16'd44257;

   // Feedback taps of the Galois generators.
   localparam logic [RAND_W-1:0] LFSR_MASK = 16'hB400;

   // Register map.
   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_ROTATE_AMOUNT   = 3'd0,
      REG_DECAY_STEP      = 3'd1,
      REG_PEAK_LEVEL      = 3'd2,
      REG_FLOOR_LEVEL     = 3'd3,
      REG_FLASH_THRESHOLD = 3'd4,
      REG_RANDOM_SEED     = 3'd5
   } csr_reg_type;

   // One pixel, three colour levels.
   typedef struct packed {
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] blue;
   } colour_type;

   // Controls of the base ring cells.
   typedef struct packed {
      logic load;
      logic fwd;
      logic back;
   } shift_ctl_type;

   // A generator value that would be zero is replaced by one.
   function automatic logic [RAND_W-1:0] nonzero16(input logic [RAND_W-1:0] v);
      nonzero16 = (v == '0) ? RAND_W'(1) : v;
   endfunction

   function automatic logic [RAND_W-1:0] lfsr_next(input logic [RAND_W-1:0] x);
      lfsr_next = x[0] ? ((x >> 1) ^ LFSR_MASK) : (x >> 1);
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/lrf_base_cell.sv */
// One cell of the base pattern ring: holds a pixel, loads it, or takes a neighbor's.
`default_nettype none

module lrf_base_cell #(
   parameter int INDEX = 0
) (
   input  wire logic                          clock,
   input  wire lrf_pkg::shift_ctl_type        ctl,
   input  wire logic [lrf_pkg::INDEX_W-1:0]   load_index,
   input  wire lrf_pkg::colour_type           load_pix,
   input  wire lrf_pkg::colour_type           fwd_pix,
   input  wire lrf_pkg::colour_type           back_pix,
   output lrf_pkg::colour_type                pix
);

   localparam logic [lrf_pkg::INDEX_W-1:0] CELL_INDEX = INDEX[lrf_pkg::INDEX_W-1:0];

   lrf_pkg::colour_type pix_ff;

   always_ff @(posedge clock) begin
      priority if (ctl.load && (load_index == CELL_INDEX)) begin
         pix_ff <= load_pix;
      end else if (ctl.fwd) begin
         pix_ff <= fwd_pix;
      end else if (ctl.back) begin
         pix_ff <= back_pix;
      end
   end

   assign pix = pix_ff;

endmodule

`default_nettype wire

/* hw/rtl/lrf_flash_lane.sv */
// One flash layer: a ring of pixel cells with a delay line that reaches the diagonal neighbor.
`default_nettype none

module lrf_flash_lane #(
   parameter int PIXEL_COUNT = lrf_pkg::PIXEL_COUNT_DEFAULT,
   parameter int BACK        = lrf_pkg::ROW_LENGTH_DEFAULT + 1
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               step,
   input  wire logic                               fire,
   input  wire logic [$clog2(PIXEL_COUNT)-1:0]     pix_idx,
   input  wire logic [lrf_pkg::LEVEL_W-1:0]        decay_step,
   input  wire logic [lrf_pkg::LEVEL_W-1:0]        peak_level,
   output lrf_pkg::colour_type                     flash_pix
);

   // Previous frame, read at cell 0 and refilled at the far end.
   lrf_pkg::colour_type cell_ff [PIXEL_COUNT];
   // Previous values already read, so that the neighbor BACK pixels earlier is at hand.
   lrf_pkg::colour_type tap_ff [BACK];
   lrf_pkg::colour_type tap_pix;
   logic                in_edge;

   function automatic logic [lrf_pkg::LEVEL_W-1:0] decay(
      input logic [lrf_pkg::LEVEL_W-1:0] c,
      input logic [lrf_pkg::LEVEL_W-1:0] d
   );
      decay = (c > d) ? (c - d) : '0;
   endfunction

   assign tap_pix = tap_ff[BACK-1];
   assign in_edge = int'(pix_idx) < BACK;

   always_comb begin
      priority if (fire) begin
         flash_pix.green = peak_level;
         flash_pix.red   = peak_level;
         flash_pix.blue  = peak_level;
      end else if (in_edge) begin
         flash_pix = '0;
      end else begin
         flash_pix.green = decay(tap_pix.green, decay_step);
         flash_pix.red   = decay(tap_pix.red, decay_step);
         flash_pix.blue  = decay(tap_pix.blue, decay_step);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIXEL_COUNT; k++) begin
            cell_ff[k] <= '0;
         end
      end else if (step) begin
         for (int k = 0; k < PIXEL_COUNT - 1; k++) begin
            cell_ff[k] <= cell_ff[k+1];
         end
         cell_ff[PIXEL_COUNT-1] <= flash_pix;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         tap_ff[0] <= cell_ff[0];
         for (int j = 1; j < BACK; j++) begin
            tap_ff[j] <= tap_ff[j-1];
         end
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/led_rainbow_flash_frame_engine.sv */
// Top level of the LED rainbow flash frame engine: base ring, two flash lanes, merge and output.
`default_nettype none

// Channel   Direction  Beat contents
// --------  ---------  ----------------------------------------------------------
// req_      in         req_type, req_pixel_index, req_green_in/red_in/blue_in
// rsp_      out        rsp_out_index, rsp_green_out/red_out/blue_out, rsp_last_pixel
// csr_      in         csr_write, csr_index, csr_data (write only, no wait)
//
// A tick beat turns the base ring by rotate_amount cells, one cell per cycle, then
// steps the rings once per result for all PIXEL_COUNT pixels; the rate is set by
// this one-pixel-per-cycle walk of the rings whenever rsp_ is not stalled.
// Reset clears both flash rings and reloads the generators; the base ring is
// undefined until every pixel has been loaded.
// A stalled rsp_ holds the result register and freezes the walk; req_ is taken
// only between frames, also while the last result of a frame still waits.

module led_rainbow_flash_frame_engine #(
   parameter int PIXEL_COUNT = lrf_pkg::PIXEL_COUNT_DEFAULT,
   parameter int ROW_LENGTH  = lrf_pkg::ROW_LENGTH_DEFAULT
) (
   input  wire logic                               clock,
   input  wire logic                               reset,

   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic                               req_type,
   input  wire logic [lrf_pkg::INDEX_W-1:0]        req_pixel_index,
   input  wire logic [lrf_pkg::LEVEL_W-1:0]        req_green_in,
   input  wire logic [lrf_pkg::LEVEL_W-1:0]        req_red_in,
   input  wire logic [lrf_pkg::LEVEL_W-1:0]        req_blue_in,

   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [lrf_pkg::INDEX_W-1:0]             rsp_out_index,
   output logic [lrf_pkg::LEVEL_W-1:0]             rsp_green_out,
   output logic [lrf_pkg::LEVEL_W-1:0]             rsp_red_out,
   output logic [lrf_pkg::LEVEL_W-1:0]             rsp_blue_out,
   output logic                                    rsp_last_pixel,

   input  wire logic                               csr_write,
   input  wire logic [lrf_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [lrf_pkg::CSR_DATA_W-1:0]     csr_data
);

   localparam int IDX_W = $clog2(PIXEL_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PIXEL_COUNT - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROTATE,
      ST_EMIT
   } state_type;

   // Control and output registers.
   state_type                          state_ff;
   logic [lrf_pkg::INDEX_W-1:0]        rot_cnt_ff;
   logic [IDX_W-1:0]                   pix_cnt_ff;
   logic                               rsp_valid_ff;
   logic [lrf_pkg::INDEX_W-1:0]        rsp_index_ff;
   lrf_pkg::colour_type                rsp_pix_ff;
   logic                               rsp_last_ff;

   // Configuration and generators.
   logic [lrf_pkg::INDEX_W-1:0]        rotate_ff;
   logic [lrf_pkg::LEVEL_W-1:0]        decay_ff;
   logic [lrf_pkg::LEVEL_W-1:0]        peak_ff;
   logic [lrf_pkg::LEVEL_W-1:0]        floor_ff;
   logic [lrf_pkg::RAND_W-1:0]         threshold_ff;
   logic [lrf_pkg::RAND_W-1:0]         up_gen_ff;
   logic [lrf_pkg::RAND_W-1:0]         down_gen_ff;

   logic                               req_fire;
   logic                               step;
   lrf_pkg::shift_ctl_type             base_ctl;
   lrf_pkg::colour_type                load_pix;
   lrf_pkg::colour_type                base_q [PIXEL_COUNT];
   lrf_pkg::colour_type                up_pix;
   lrf_pkg::colour_type                down_pix;
   lrf_pkg::colour_type                merged_pix;
   logic [lrf_pkg::RAND_W-1:0]         up_gen_in;
   logic [lrf_pkg::RAND_W-1:0]         down_gen_in;
   logic                               up_fire;
   logic                               down_fire;
   logic [lrf_pkg::INDEX_W-1:0]        pix_index_ext;

   // Sum of the three layers, clamped to the floor first and then to the peak.
   function automatic logic [lrf_pkg::LEVEL_W-1:0] merge_level(
      input logic [lrf_pkg::LEVEL_W-1:0] a,
      input logic [lrf_pkg::LEVEL_W-1:0] b,
      input logic [lrf_pkg::LEVEL_W-1:0] c,
      input logic [lrf_pkg::LEVEL_W-1:0] floor_lv,
      input logic [lrf_pkg::LEVEL_W-1:0] peak_lv
   );
      logic [lrf_pkg::LEVEL_W+1:0] sum;
      logic [lrf_pkg::LEVEL_W+1:0] low;
      sum = (lrf_pkg::LEVEL_W+2)'(a) + (lrf_pkg::LEVEL_W+2)'(b) + (lrf_pkg::LEVEL_W+2)'(c);
      low = (sum < (lrf_pkg::LEVEL_W+2)'(floor_lv)) ? (lrf_pkg::LEVEL_W+2)'(floor_lv) : sum;
      merge_level = (low > (lrf_pkg::LEVEL_W+2)'(peak_lv)) ? peak_lv
                                                             : low[lrf_pkg::LEVEL_W-1:0];
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;

   // The walk advances only when the result register is free or being emptied.
   assign step = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);

   assign base_ctl.load = req_fire && !req_type;
   assign base_ctl.fwd  = (state_ff == ST_ROTATE);
   assign base_ctl.back = step;

   assign load_pix.green = req_green_in;
   assign load_pix.red   = req_red_in;
   assign load_pix.blue  = req_blue_in;

   // The base ring turns forward one cell per cycle while rotating, and backward
   // one cell per result while emitting, so that cell 0 shows the pixels in order
   // and the ring is back in place after a whole frame.
   for (genvar k = 0; k < PIXEL_COUNT; k++) begin : g_base
      lrf_base_cell #(
         .INDEX(k)
      ) u_cell (
         .clock      (clock),
         .ctl        (base_ctl),
         .load_index (req_pixel_index),
         .load_pix   (load_pix),
         .fwd_pix    (base_q[(k + PIXEL_COUNT - 1) % PIXEL_COUNT]),
         .back_pix   (base_q[(k + 1) % PIXEL_COUNT]),
         .pix        (base_q[k])
      );
   end

   // Each generator steps once per pixel; the new value decides the flash.
   assign up_gen_in   = lrf_pkg::lfsr_next(up_gen_ff);
   assign down_gen_in = lrf_pkg::lfsr_next(down_gen_ff);
   assign up_fire     = up_gen_in < threshold_ff;
   assign down_fire   = down_gen_in < threshold_ff;

   lrf_flash_lane #(
      .PIXEL_COUNT (PIXEL_COUNT),
      .BACK        (ROW_LENGTH + 1)
   ) u_up_lane (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .fire       (up_fire),
      .pix_idx    (pix_cnt_ff),
      .decay_step (decay_ff),
      .peak_level (peak_ff),
      .flash_pix  (up_pix)
   );

   lrf_flash_lane #(
      .PIXEL_COUNT (PIXEL_COUNT),
      .BACK        (ROW_LENGTH - 1)
   ) u_down_lane (
      .clock      (clock),
      .reset      (reset),
      .step       (step),
      .fire       (down_fire),
      .pix_idx    (pix_cnt_ff),
      .decay_step (decay_ff),
      .peak_level (peak_ff),
      .flash_pix  (down_pix)
   );

   assign merged_pix.green = merge_level(base_q[0].green, up_pix.green, down_pix.green,
                                         floor_ff, peak_ff);
   assign merged_pix.red   = merge_level(base_q[0].red, up_pix.red, down_pix.red,
                                         floor_ff, peak_ff);
   assign merged_pix.blue  = merge_level(base_q[0].blue, up_pix.blue, down_pix.blue,
                                         floor_ff, peak_ff);

   always_comb begin
      pix_index_ext = '0;
      pix_index_ext[IDX_W-1:0] = pix_cnt_ff;
   end

   // Sequencer: state, counters and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rot_cnt_ff   <= '0;
         pix_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire && req_type) begin
                  pix_cnt_ff <= '0;
                  rot_cnt_ff <= rotate_ff;
                  state_ff   <= (rotate_ff == '0) ? ST_EMIT : ST_ROTATE;
               end
            end
            ST_ROTATE: begin
               rot_cnt_ff <= rot_cnt_ff - 1'b1;
               if (rot_cnt_ff == lrf_pkg::INDEX_W'(1)) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (step) begin
                  pix_cnt_ff <= pix_cnt_ff + 1'b1;
                  if (pix_cnt_ff == LAST_IDX) begin
                     state_ff <= ST_IDLE;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         priority if (step) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end

      if (step) begin
         rsp_index_ff <= pix_index_ext;
         rsp_pix_ff   <= merged_pix;
         rsp_last_ff  <= (pix_cnt_ff == LAST_IDX);
      end
   end

   // Configuration registers and the two generators. Writing the seed reloads
   // both generators, the second one with the inverted seed.
   always_ff @(posedge clock) begin
      if (reset) begin
         rotate_ff    <= lrf_pkg::ROTATE_RESET;
         decay_ff     <= lrf_pkg::DECAY_RESET;
         peak_ff      <= lrf_pkg::PEAK_RESET;
         floor_ff     <= lrf_pkg::FLOOR_RESET;
         threshold_ff <= lrf_pkg::THRESHOLD_RESET;
         up_gen_ff    <= lrf_pkg::nonzero16(lrf_pkg::SEED_RESET);
         down_gen_ff  <= lrf_pkg::nonzero16(~lrf_pkg::SEED_RESET);
      end else begin
         priority if (csr_write) begin
            unique case (lrf_pkg::csr_reg_type'(csr_index))
               lrf_pkg::REG_ROTATE_AMOUNT: begin
                  rotate_ff <= csr_data[lrf_pkg::INDEX_W-1:0];
               end
               lrf_pkg::REG_DECAY_STEP: begin
                  decay_ff <= csr_data[lrf_pkg::LEVEL_W-1:0];
               end
               lrf_pkg::REG_PEAK_LEVEL: begin
                  peak_ff <= csr_data[lrf_pkg::LEVEL_W-1:0];
               end
               lrf_pkg::REG_FLOOR_LEVEL: begin
                  floor_ff <= csr_data[lrf_pkg::LEVEL_W-1:0];
               end
               lrf_pkg::REG_FLASH_THRESHOLD: begin
                  threshold_ff <= csr_data[lrf_pkg::RAND_W-1:0];
               end
               lrf_pkg::REG_RANDOM_SEED: begin
                  up_gen_ff   <= lrf_pkg::nonzero16(csr_data[lrf_pkg::RAND_W-1:0]);
                  down_gen_ff <= lrf_pkg::nonzero16(~csr_data[lrf_pkg::RAND_W-1:0]);
               end
               default: begin
               end
            endcase
         end else if (step) begin
            up_gen_ff   <= up_gen_in;
            down_gen_ff <= down_gen_in;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_index  = rsp_index_ff;
   assign rsp_green_out  = rsp_pix_ff.green;
   assign rsp_red_out    = rsp_pix_ff.red;
   assign rsp_blue_out   = rsp_pix_ff.blue;
   assign rsp_last_pixel = rsp_last_ff;

endmodule

`default_nettype wire

/* hw/rtl/lrf_checker.sv */
// Port-level checks of the LED rainbow flash frame engine and their binding.
`default_nettype none

module lrf_checker #(
   parameter int PIXEL_COUNT = lrf_pkg::PIXEL_COUNT_DEFAULT
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_ready,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic [lrf_pkg::INDEX_W-1:0]   rsp_out_index,
   input wire logic [lrf_pkg::LEVEL_W-1:0]   rsp_green_out,
   input wire logic [lrf_pkg::LEVEL_W-1:0]   rsp_red_out,
   input wire logic [lrf_pkg::LEVEL_W-1:0]   rsp_blue_out,
   input wire logic                          rsp_last_pixel
);

   // A stalled result beat holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_index)
         && $stable(rsp_green_out) && $stable(rsp_red_out) && $stable(rsp_blue_out)
         && $stable(rsp_last_pixel))
      else $error("result beat changed while stalled");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // The last-pixel flag marks exactly the final pixel of a frame.
   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last_pixel == (rsp_out_index == lrf_pkg::INDEX_W'(PIXEL_COUNT - 1))))
      else $error("last pixel flag does not match index");

   // Within a frame the next pixel follows right after a taken beat.
   a_next_pixel: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_pixel
         |=> rsp_valid && (rsp_out_index == $past(rsp_out_index) + 1'b1))
      else $error("frame pixels not consecutive");

   // No request is taken while a frame is still being emitted.
   a_busy_frame: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_pixel |-> !req_ready)
      else $error("request taken in the middle of a frame");

endmodule

bind led_rainbow_flash_frame_engine lrf_checker #(
   .PIXEL_COUNT (PIXEL_COUNT)
) u_lrf_checker (.*);

`default_nettype wire

/* test/tb_led_rainbow_flash_frame_engine.sv */
// Self-checking testbench of the LED rainbow flash frame engine: a directed table, then random frames.

module tb_led_rainbow_flash_frame_engine;
   import lrf_pkg::*;

   // Geometry of the block under test and pacing of the run.
   localparam int PIXELS           = PIXEL_COUNT_DEFAULT;
   localparam int ROW_LEN          = ROW_LENGTH_DEFAULT;
   localparam int CYCLE_LIMIT      = 400000;
   // A load is written into its cell as it is taken and a frame is over once its
   // last pixel is out, so a short pause is enough before touching the registers.
   localparam int SETTLE_CYCLES    = 16;
   // After the last pixel beat, wait longer than a full frame walk plus the largest rotation.
   localparam int DRAIN_CYCLES     = 2 * PIXELS + 64;
   localparam int RANDOM_PHASES    = 6;
   localparam int PHASE_ITEMS      = 32;
   localparam int LONG_HOLD_CYCLES = 400;

   // Register indexes past the end of the map; writes there must change nothing.
   localparam logic [CSR_INDEX_W-1:0] SPARE_REG_LOW  = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] SPARE_REG_HIGH = 3'd7;

   typedef enum logic {REQ_LOAD = 1'b0, REQ_TICK = 1'b1} req_kind_e;
   typedef enum logic [1:0] {ROW_LOAD, ROW_TICK, ROW_CSR} row_kind_e;

   // One expected pixel beat on the result channel.
   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] blue;
      logic               last;
   } pixel_beat_t;

   // One row of the directed table. When known is set, every pixel of the frame
   // that the row starts must come out at known_level on all three colours.
   typedef struct packed {
      row_kind_e             kind;
      logic [CSR_INDEX_W-1:0] reg_index;
      logic [CSR_DATA_W-1:0]  reg_value;
      logic [INDEX_W-1:0]     pixel;
      logic [LEVEL_W-1:0]     green;
      logic [LEVEL_W-1:0]     red;
      logic [LEVEL_W-1:0]     blue;
      logic                   known;
      logic [LEVEL_W-1:0]     known_level;
   } plan_row_t;

   logic clock;
   logic reset;

   logic                   req_valid;
   logic                   req_ready;
   logic                   req_type;
   logic [INDEX_W-1:0]     req_pixel_index;
   logic [LEVEL_W-1:0]     req_green_in;
   logic [LEVEL_W-1:0]     req_red_in;
   logic [LEVEL_W-1:0]     req_blue_in;

   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [INDEX_W-1:0]     rsp_out_index;
   logic [LEVEL_W-1:0]     rsp_green_out;
   logic [LEVEL_W-1:0]     rsp_red_out;
   logic [LEVEL_W-1:0]     rsp_blue_out;
   logic                   rsp_last_pixel;

   logic                   csr_write;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   led_rainbow_flash_frame_engine #(
      .PIXEL_COUNT(PIXELS),
      .ROW_LENGTH (ROW_LEN)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_pixel_index(req_pixel_index),
      .req_green_in   (req_green_in),
      .req_red_in     (req_red_in),
      .req_blue_in    (req_blue_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_index  (rsp_out_index),
      .rsp_green_out  (rsp_green_out),
      .rsp_red_out    (rsp_red_out),
      .rsp_blue_out   (rsp_blue_out),
      .rsp_last_pixel (rsp_last_pixel),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Frame predictor: its own copy of the three pixel layers, the two flash
   // generators and the register file, advanced once per accepted beat.
   // ------------------------------------------------------------------------
   colour_type             base_px  [PIXELS];
   colour_type             up_px    [PIXELS];
   colour_type             down_px  [PIXELS];
   logic [RAND_W-1:0]      up_gen;
   logic [RAND_W-1:0]      down_gen;
   logic [INDEX_W-1:0]     rotate_r;
   logic [LEVEL_W-1:0]     decay_r;
   logic [LEVEL_W-1:0]     peak_r;
   logic [LEVEL_W-1:0]     floor_r;
   logic [RAND_W-1:0]      threshold_r;
   logic [RAND_W-1:0]      seed_r;

   pixel_beat_t pixels_due[$];

   int  cycle_count  = 0;
   int  mismatches   = 0;
   int  beats_out    = 0;
   int  loads_sent   = 0;
   int  ticks_sent   = 0;
   int  long_holds   = 0;
   int  burst_left   = 0;
   bit  hold_requested = 1'b0;

   // Both generators restart from the seed; the down one runs on its complement.
   // A value that would load as zero loads as one, since zero locks the register.
   task automatic load_generators();
      up_gen   = (seed_r == '0) ? RAND_W'(1) : seed_r;
      down_gen = (~seed_r == '0) ? RAND_W'(1) : ~seed_r;
   endtask

   task automatic reset_frame_model();
      foreach (base_px[i]) begin
         base_px[i] = '0;
         up_px[i]   = '0;
         down_px[i] = '0;
      end
      rotate_r    = ROTATE_RESET;
      decay_r     = DECAY_RESET;
      peak_r      = PEAK_RESET;
      floor_r     = FLOOR_RESET;
      threshold_r = THRESHOLD_RESET;
      seed_r      = SEED_RESET;
      load_generators();
   endtask

   // Galois step: shift right, fold the taps back in when a one drops out.
   function automatic logic [RAND_W-1:0] next_draw(input logic [RAND_W-1:0] x);
      next_draw = {1'b0, x[RAND_W-1:1]} ^ (x[0] ? LFSR_MASK : '0);
   endfunction

   function automatic logic [LEVEL_W-1:0] fade(input logic [LEVEL_W-1:0] c);
      fade = (c > decay_r) ? c - decay_r : '0;
   endfunction

   // Floor first, then peak, so a floor above the peak yields the peak.
   function automatic logic [LEVEL_W-1:0] blend(input logic [LEVEL_W-1:0] a,
                                                input logic [LEVEL_W-1:0] b,
                                                input logic [LEVEL_W-1:0] c);
      int sum;
      sum = int'(a) + int'(b) + int'(c);
      if (sum < int'(floor_r)) sum = int'(floor_r);
      if (sum > int'(peak_r)) sum = int'(peak_r);
      blend = sum[LEVEL_W-1:0];
   endfunction

   // One flash layer: each pixel draws once in pixel order; a draw under the
   // threshold fires it at peak, otherwise it inherits its diagonal neighbour
   // from the previous frame less the decay, or goes dark off the top edge.
   task automatic advance_flash(input bit down_layer);
      colour_type        prev [PIXELS];
      colour_type        fresh;
      logic [RAND_W-1:0] gen;
      int                reach;
      if (down_layer) begin
         foreach (prev[i]) prev[i] = down_px[i];
         gen   = down_gen;
         reach = ROW_LEN - 1;
      end else begin
         foreach (prev[i]) prev[i] = up_px[i];
         gen   = up_gen;
         reach = ROW_LEN + 1;
      end
      for (int i = 0; i < PIXELS; i++) begin
         gen = next_draw(gen);
         if (gen < threshold_r) begin
            fresh = {peak_r, peak_r, peak_r};
         end else if (i < reach) begin
            fresh = '0;
         end else begin
            fresh = {fade(prev[i-reach].green), fade(prev[i-reach].red),
                     fade(prev[i-reach].blue)};
         end
         if (down_layer) down_px[i] = fresh;
         else up_px[i] = fresh;
      end
      if (down_layer) down_gen = gen;
      else up_gen = gen;
   endtask

   // A tick turns the base ring, moves both flash layers and queues the whole
   // merged frame. A known level overrides the computed colours of the frame.
   task automatic advance_frame(input logic known, input logic [LEVEL_W-1:0] known_level);
      colour_type  old_base [PIXELS];
      pixel_beat_t beat;
      foreach (old_base[i]) old_base[i] = base_px[i];
      foreach (base_px[i]) base_px[i] = old_base[(i + PIXELS - int'(rotate_r)) % PIXELS];
      advance_flash(1'b0);
      advance_flash(1'b1);
      for (int i = 0; i < PIXELS; i++) begin
         beat.index = i[INDEX_W-1:0];
         if (known) begin
            beat.green = known_level;
            beat.red   = known_level;
            beat.blue  = known_level;
         end else begin
            beat.green = blend(base_px[i].green, up_px[i].green, down_px[i].green);
            beat.red   = blend(base_px[i].red,   up_px[i].red,   down_px[i].red);
            beat.blue  = blend(base_px[i].blue,  up_px[i].blue,  down_px[i].blue);
         end
         beat.last = (i == PIXELS - 1);
         pixels_due.push_back(beat);
      end
   endtask

   // Narrow registers keep only their low bits; unmapped indexes are dropped.
   task automatic apply_register_write(input logic [CSR_INDEX_W-1:0] idx,
                                       input logic [CSR_DATA_W-1:0]  value);
      case (idx)
         REG_ROTATE_AMOUNT:   rotate_r    = value[INDEX_W-1:0];
         REG_DECAY_STEP:      decay_r     = value[LEVEL_W-1:0];
         REG_PEAK_LEVEL:      peak_r      = value[LEVEL_W-1:0];
         REG_FLOOR_LEVEL:     floor_r     = value[LEVEL_W-1:0];
         REG_FLASH_THRESHOLD: threshold_r = value;
         REG_RANDOM_SEED: begin
            seed_r = value;
            load_generators();
         end
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------------
   // Drivers. Everything changes on the falling edge; handshakes are judged on
   // the rising edge.
   // ------------------------------------------------------------------------

   // Offers one beat and returns once it is accepted. The sender runs in bursts:
   // when a burst is used up it drops valid for a random gap and starts a new
   // one, sometimes long enough to give stretches with no idling at all.
   task automatic offer_beat(input req_kind_e kind, input logic [INDEX_W-1:0] pixel,
                             input logic [LEVEL_W-1:0] g, input logic [LEVEL_W-1:0] r,
                             input logic [LEVEL_W-1:0] b, input logic known,
                             input logic [LEVEL_W-1:0] known_level);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(1, 10);
         gap = $urandom_range(1, 12);
      end
      burst_left--;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid       <= 1'b1;
      req_type        <= kind;
      req_pixel_index <= pixel;
      req_green_in    <= g;
      req_red_in      <= r;
      req_blue_in     <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (kind == REQ_LOAD) begin
         base_px[pixel] = {g, r, b};
         loads_sent++;
      end else begin
         advance_frame(known, known_level);
         ticks_sent++;
      end
   endtask

   // Stops offering, waits for the last expected pixel, then lets the block
   // finish whatever a trailing load left in flight.
   task automatic settle_block();
      if (req_valid) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      while (pixels_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0]  value);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      apply_register_write(idx, value);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic plan_row_t csr_row(input logic [CSR_INDEX_W-1:0] idx,
                                         input logic [CSR_DATA_W-1:0]  value);
      csr_row = '{ROW_CSR, idx, value, '0, '0, '0, '0, 1'b0, '0};
   endfunction

   function automatic plan_row_t load_row(input logic [INDEX_W-1:0] pixel,
                                          input logic [LEVEL_W-1:0] g,
                                          input logic [LEVEL_W-1:0] r,
                                          input logic [LEVEL_W-1:0] b);
      load_row = '{ROW_LOAD, '0, '0, pixel, g, r, b, 1'b0, '0};
   endfunction

   function automatic plan_row_t tick_row(input logic known, input logic [LEVEL_W-1:0] level);
      tick_row = '{ROW_TICK, '0, '0, '0, '0, '0, '0, known, level};
   endfunction

   // Mostly uniform levels, with the two extremes pulled in often.
   function automatic logic [LEVEL_W-1:0] pick_level();
      case ($urandom_range(0, 7))
         0:       pick_level = '0;
         1:       pick_level = '1;
         default: pick_level = $urandom_range(0, 255);
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Receiver. It switches between patterns of its own: always ready, coin
   // flips, a sparse periodic pattern, and rare acceptance that leaves long stalls.
   // On request it also holds off for a long stretch so that a frame freezes
   // in the middle and the block stops taking beats.
   // ------------------------------------------------------------------------
   initial begin : receiver
      int mode;
      int mode_left;
      int held;
      rsp_ready = 1'b0;
      mode      = 0;
      mode_left = 0;
      forever begin
         @(negedge clock);
         if (hold_requested) begin
            hold_requested = 1'b0;
            rsp_ready <= 1'b0;
            for (held = 0; held < LONG_HOLD_CYCLES; held++) @(negedge clock);
            long_holds++;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(20, 200);
         end
         mode_left--;
         case (mode)
            0:       rsp_ready <= 1'b1;
            1:       rsp_ready <= ($urandom_range(0, 1) == 1);
            2:       rsp_ready <= (mode_left % 4 == 0);
            default: rsp_ready <= ($urandom_range(0, 7) == 0);
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Checker: every accepted pixel beat is matched against the oldest one the
   // predictor queued, field by field.
   // ------------------------------------------------------------------------
   task automatic report_field(input string field, input int pixel,
                               input logic [LEVEL_W-1:0] want, input logic [LEVEL_W-1:0] got);
      mismatches++;
      $display("%0t: pixel %0d %s expected %0d got %0d", $time, pixel, field, want, got);
   endtask

   always @(posedge clock) begin : pixel_checker
      pixel_beat_t want;
      if (!reset && rsp_valid && rsp_ready) begin
         beats_out++;
         if (pixels_due.size() == 0) begin
            mismatches++;
            $display("%0t: pixel beat %0d arrived with none expected", $time, rsp_out_index);
         end else begin
            want = pixels_due.pop_front();
            if (rsp_out_index !== want.index)
               report_field("index", want.index, want.index, rsp_out_index);
            if (rsp_green_out !== want.green)
               report_field("green", want.index, want.green, rsp_green_out);
            if (rsp_red_out !== want.red)
               report_field("red", want.index, want.red, rsp_red_out);
            if (rsp_blue_out !== want.blue)
               report_field("blue", want.index, want.blue, rsp_blue_out);
            if (rsp_last_pixel !== want.last)
               report_field("last", want.index, want.last, rsp_last_pixel);
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: cycle limit reached with %0d pixel beats outstanding",
                  $time, pixels_due.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Stimulus.
   // ------------------------------------------------------------------------
   initial begin : stimulus
      plan_row_t         plan[$];
      plan_row_t         row;
      logic [RAND_W-1:0] noise;
      logic [RAND_W-1:0] threshold;
      logic [LEVEL_W-1:0] decay;
      bit                wrote_last;

      reset           = 1'b1;
      req_valid       = 1'b0;
      req_type        = REQ_LOAD;
      req_pixel_index = '0;
      req_green_in    = '0;
      req_red_in      = '0;
      req_blue_in     = '0;
      csr_write       = 1'b0;
      csr_index       = REG_ROTATE_AMOUNT;
      csr_data        = '0;
      reset_frame_model();

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The base ring is undefined until written, so every pixel is loaded
      // before the first tick. Pixel 0 starts dark and the last one white.
      for (int p = 0; p < PIXELS; p++) begin
         if (p == 0)
            offer_beat(REQ_LOAD, p, '0, '0, '0, 1'b0, '0);
         else if (p == PIXELS - 1)
            offer_beat(REQ_LOAD, p, '1, '1, '1, 1'b0, '0);
         else
            offer_beat(REQ_LOAD, p, pick_level(), pick_level(), pick_level(), 1'b0, '0);
      end

      // Directed table. Frames with a typed level are fully determined by the
      // clamps; all other frames are checked against the predictor.
      plan.push_back(tick_row(1'b0, '0));                  // reset settings
      plan.push_back(csr_row(REG_PEAK_LEVEL, 16'd0));      // peak of zero darkens all
      plan.push_back(tick_row(1'b1, 8'd0));
      plan.push_back(csr_row(REG_FLOOR_LEVEL, 16'd200));   // floor above peak gives peak
      plan.push_back(csr_row(REG_PEAK_LEVEL, 16'd40));
      plan.push_back(tick_row(1'b1, 8'd40));
      plan.push_back(csr_row(REG_PEAK_LEVEL, 16'd255));    // both clamps at full scale
      plan.push_back(csr_row(REG_FLOOR_LEVEL, 16'd255));
      plan.push_back(tick_row(1'b1, 8'd255));
      plan.push_back(csr_row(REG_FLOOR_LEVEL, 16'd0));     // no rotation
      plan.push_back(csr_row(REG_ROTATE_AMOUNT, 16'd0));
      plan.push_back(tick_row(1'b0, '0));
      plan.push_back(csr_row(REG_ROTATE_AMOUNT, 16'd63));  // largest rotation, no flashes,
      plan.push_back(csr_row(REG_FLASH_THRESHOLD, 16'd0)); // full decay kills old ones
      plan.push_back(csr_row(REG_DECAY_STEP, 16'd255));
      plan.push_back(tick_row(1'b0, '0));
      plan.push_back(csr_row(REG_FLASH_THRESHOLD, 16'hFFFF)); // nearly every draw fires
      plan.push_back(csr_row(REG_DECAY_STEP, 16'd0));
      plan.push_back(csr_row(REG_RANDOM_SEED, 16'd0));     // zero seed on the up generator
      plan.push_back(tick_row(1'b0, '0));
      plan.push_back(tick_row(1'b0, '0));
      plan.push_back(csr_row(REG_RANDOM_SEED, 16'hFFFF));  // zero seed on the down generator
      plan.push_back(csr_row(REG_FLASH_THRESHOLD, 16'd3000));
      plan.push_back(csr_row(REG_DECAY_STEP, 16'd17));
      plan.push_back(tick_row(1'b0, '0));
      plan.push_back(csr_row(SPARE_REG_LOW, 16'hFFFF));    // unmapped indexes do nothing
      plan.push_back(csr_row(SPARE_REG_HIGH, 16'h1234));
      plan.push_back(csr_row(REG_ROTATE_AMOUNT, 16'hFFC1)); // upper data bits dropped
      plan.push_back(tick_row(1'b0, '0));
      plan.push_back(load_row(6'd0, 8'hFF, 8'h00, 8'hFF));
      plan.push_back(load_row(6'd63, 8'h00, 8'hFF, 8'h00));
      plan.push_back(load_row(6'd42, 8'hAA, 8'h55, 8'hAA));
      plan.push_back(load_row(6'd21, 8'h55, 8'hAA, 8'h55));
      plan.push_back(tick_row(1'b0, '0));
      plan.push_back(csr_row(REG_FLOOR_LEVEL, 16'd100));   // narrow clamp window
      plan.push_back(csr_row(REG_PEAK_LEVEL, 16'd180));
      plan.push_back(tick_row(1'b0, '0));
      plan.push_back(csr_row(REG_PEAK_LEVEL, 16'd255));
      plan.push_back(csr_row(REG_FLOOR_LEVEL, 16'd0));
      plan.push_back(tick_row(1'b0, '0));

      // The bench moves registers only while the block is idle, which the block itself does
      // not enforce, so the first write after any beat waits for the frame to drain.
      wrote_last = 1'b1;
      foreach (plan[n]) begin
         row = plan[n];
         if (row.kind == ROW_CSR) begin
            if (!wrote_last) settle_block();
            write_register(row.reg_index, row.reg_value);
            wrote_last = 1'b1;
         end else begin
            offer_beat((row.kind == ROW_TICK) ? REQ_TICK : REQ_LOAD, row.pixel,
                       row.green, row.red, row.blue, row.known, row.known_level);
            wrote_last = 1'b0;
         end
      end

      // Random phases. Each starts idle with a fresh register setting, then
      // mixes loads and ticks; the flash threshold is kept low most of the
      // time so that flashes travel down the diagonals over several frames.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle_block();
         noise = $urandom;
         write_register(REG_ROTATE_AMOUNT,
                        {noise[15:6], (phase == 1) ? 6'd0 :
                                      (phase == 2) ? 6'd63 : 6'($urandom_range(0, 63))});
         case ($urandom_range(0, 3))
            0:       decay = '0;
            1:       decay = '1;
            2:       decay = $urandom_range(0, 255);
            default: decay = $urandom_range(1, 24);
         endcase
         noise = $urandom;
         write_register(REG_DECAY_STEP, {noise[15:8], decay});
         noise = $urandom;
         write_register(REG_PEAK_LEVEL,
                        {noise[15:8], ($urandom_range(0, 3) == 0) ? pick_level() : 8'hFF});
         noise = $urandom;
         write_register(REG_FLOOR_LEVEL,
                        {noise[15:8], ($urandom_range(0, 3) == 0) ? pick_level()
                                                                 : 8'($urandom_range(0, 30))});
         case ($urandom_range(0, 5))
            0:       threshold = '0;
            1:       threshold = '1;
            2:       threshold = $urandom_range(0, 65535);
            default: threshold = $urandom_range(100, 8000);
         endcase
         write_register(REG_FLASH_THRESHOLD, threshold);
         if (phase == 0 || $urandom_range(0, 1) == 1)
            write_register(REG_RANDOM_SEED,
                           ($urandom_range(0, 7) == 0) ? 16'd0 : 16'($urandom_range(1, 65535)));
         if (phase == 3) write_register(SPARE_REG_LOW, $urandom_range(0, 65535));

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // In the third phase the receiver stops for a long while just as a
            // frame starts, and the sender keeps offering behind it.
            if (phase == 2 && k == 4) begin
               hold_requested = 1'b1;
               offer_beat(REQ_TICK, $urandom_range(0, 63), pick_level(), pick_level(),
                          pick_level(), 1'b0, '0);
            end else begin
               // Halfway through the fifth phase the sender waits for a clean drain.
               if (phase == 4 && k == PHASE_ITEMS / 2) settle_block();
               if ($urandom_range(0, 3) == 0)
                  offer_beat(REQ_TICK, $urandom_range(0, 63), pick_level(), pick_level(),
                             pick_level(), 1'b0, '0);
               else
                  offer_beat(REQ_LOAD, $urandom_range(0, 63), pick_level(), pick_level(),
                             pick_level(), 1'b0, '0);
            end
         end
      end

      settle_block();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Covered %0d pixel loads and %0d frame ticks across %0d register settings,",
               loads_sent, ticks_sent, RANDOM_PHASES + 1);
      $display("checking %0d pixel beats with %0d long receiver hold(s) and %0d mismatches.",
               beats_out, long_holds, mismatches);
      if (mismatches == 0 && pixels_due.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

/* led_rainbow_flash_frame_engine.f */
hw/rtl/lrf_pkg.sv
hw/rtl/lrf_base_cell.sv
hw/rtl/lrf_flash_lane.sv
hw/rtl/led_rainbow_flash_frame_engine.sv
hw/rtl/lrf_checker.sv
test/tb_led_rainbow_flash_frame_engine.sv
